FILE: rtl/battery_percent_tracker_unit_assert.svh
// Assertion macros for the battery percent tracker checker.
`ifndef BATTERY_PERCENT_TRACKER_UNIT_ASSERT_SVH
`define BATTERY_PERCENT_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Delayed implication: the consequent is checked later than in BPT_ASSERT_NEXT.
`define BPT_ASSERT_LATER(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> ##1 (cons)) \
		else $error(msg);

`endif

FILE: rtl/bpt_pkg.sv
// Shared types, constants and helpers for the battery percent tracker.
`default_nettype none
package bpt_pkg;

	localparam int unsigned VBAT_W   = 10;
	localparam int unsigned LEVEL_W  = 11;
	localparam int unsigned OFS_W    = 8;
	localparam int unsigned HOLD_W   = 12;
	localparam int unsigned EMPTY_W  = 10;
	localparam int unsigned PCT_W    = 7;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 12;

	localparam logic [PCT_W-1:0]   PCT_FULL   = 7'd100;
	localparam logic [PCT_W-1:0]   PULSE_LOW  = 7'd10;
	localparam logic [LEVEL_W-1:0] FULL_SPAN  = 11'd50;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 11'd1533;

	localparam logic [OFS_W-1:0]   RUN_OFFSET_RST  = 8'd0;
	localparam logic [OFS_W-1:0]   HEAT_OFFSET_RST = 8'd0;
	localparam logic [OFS_W-1:0]   DROP_MARGIN_RST = 8'd12;
	localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST  = 12'd1500;
	localparam logic [EMPTY_W-1:0] EMPTY_LEVEL_RST = 10'd350;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RUN_OFFSET  = 3'd0,
		REG_HEAT_OFFSET = 3'd1,
		REG_DROP_MARGIN = 3'd2,
		REG_HOLD_TICKS  = 3'd3,
		REG_EMPTY_LEVEL = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [OFS_W-1:0]   run_offset;
		logic [OFS_W-1:0]   heat_offset;
		logic [OFS_W-1:0]   drop_margin;
		logic [HOLD_W-1:0]  hold_ticks;
		logic [EMPTY_W-1:0] empty_level;
	} cfg_t;

	// Percent values that land on a reporting step of twenty.
	function automatic logic is_mult20(input logic [PCT_W-1:0] p);
		return (p == 7'd0) || (p == 7'd20) || (p == 7'd40) || (p == 7'd60) ||
			(p == 7'd80) || (p == 7'd100);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/battery_percent_tracker_unit.sv
// Battery percent tracker: top level with input and result registers.
//
// Usage:
//  - One item per tick enters on the input channel (in_valid / in_stall):
//    vbat_reading plus the motor_running, heater_on and charging flags.
//  - Each item gives exactly one result on the output channel
//    (out_valid / out_stall): percent, update_pulse and filtered_level.
//  - An accepted item is held in the input register, then the filter and
//    percent logic load the result register, which drives out_valid.
//    Throughput is one item per cycle while out_stall is low.
//  - A stalled result holds in the result register while the input register
//    still takes one more item; in_stall rises only when both are full.
//  - Registers are written through cfg_we / cfg_index / cfg_data by the user,
//    only while no item is in flight (unchecked); unknown indexes are dropped.
//  - Reset clears both valid bits, the tracking state (held level, hold
//    countdown, percent) and loads the register defaults. The first item
//    after reset seeds the held level and percent and raises update_pulse.
`default_nettype none
module battery_percent_tracker_unit
	import bpt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [VBAT_W-1:0]     vbat_reading,
	input  wire logic                  motor_running,
	input  wire logic                  heater_on,
	input  wire logic                  charging,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [PCT_W-1:0]      percent,
	output logic                       update_pulse,
	output logic      [LEVEL_W-1:0]    filtered_level
);

	cfg_t               cfg;
	logic               valid_s1;
	logic [VBAT_W-1:0]  vbat_s1;
	logic               motor_s1;
	logic               heat_s1;
	logic               chg_s1;
	logic               valid_s2;
	logic [PCT_W-1:0]   percent_s2;
	logic               pulse_s2;
	logic [LEVEL_W-1:0] level_s2;
	logic               load_s2;
	logic               adv;
	logic [LEVEL_W-1:0] level_f;
	logic [PCT_W-1:0]   pct_next;
	logic               pulse;

	assign load_s2  = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && load_s2;
	assign in_stall = valid_s1 && !load_s2;

	bpt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			vbat_s1  <= vbat_reading;
			motor_s1 <= motor_running;
			heat_s1  <= heater_on;
			chg_s1   <= charging;
		end
	end

	bpt_filter u_filter (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.vbat_reading  (vbat_s1),
		.motor_running (motor_s1),
		.heater_on     (heat_s1),
		.cfg           (cfg),
		.level_f       (level_f)
	);

	bpt_percent u_percent (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.level_f     (level_f),
		.charging    (chg_s1),
		.empty_level (cfg.empty_level),
		.pct_next    (pct_next),
		.pulse       (pulse)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			percent_s2 <= pct_next;
			pulse_s2   <= pulse;
			level_s2   <= level_f;
		end
	end

	assign out_valid      = valid_s2;
	assign percent        = percent_s2;
	assign update_pulse   = pulse_s2;
	assign filtered_level = level_s2;

endmodule
`default_nettype wire

FILE: rtl/bpt_cfg.sv
// Configuration register file of the battery percent tracker.
`default_nettype none
module bpt_cfg
	import bpt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_offset  <= RUN_OFFSET_RST;
			cfg_q.heat_offset <= HEAT_OFFSET_RST;
			cfg_q.drop_margin <= DROP_MARGIN_RST;
			cfg_q.hold_ticks  <= HOLD_TICKS_RST;
			cfg_q.empty_level <= EMPTY_LEVEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RUN_OFFSET:  cfg_q.run_offset  <= cfg_data[OFS_W-1:0];
				REG_HEAT_OFFSET: cfg_q.heat_offset <= cfg_data[OFS_W-1:0];
				REG_DROP_MARGIN: cfg_q.drop_margin <= cfg_data[OFS_W-1:0];
				REG_HOLD_TICKS:  cfg_q.hold_ticks  <= cfg_data[HOLD_W-1:0];
				REG_EMPTY_LEVEL: cfg_q.empty_level <= cfg_data[EMPTY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/bpt_filter.sv
// Load compensation and stall-glitch hold of the battery reading.
`default_nettype none
module bpt_filter
	import bpt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic [VBAT_W-1:0]  vbat_reading,
	input  wire logic               motor_running,
	input  wire logic               heater_on,
	input  wire cfg_t               cfg,
	output logic      [LEVEL_W-1:0] level_f
);

	logic [LEVEL_W-1:0] held_level_q;
	logic [HOLD_W-1:0]  hold_count_q;
	logic [LEVEL_W-1:0] level_raw;
	logic [LEVEL_W-1:0] held_seed;
	logic [LEVEL_W:0]   drop_floor;
	logic               glitch;

	assign level_raw = {1'b0, vbat_reading}
		+ (motor_running ? {3'b000, cfg.run_offset} : '0)
		+ (heater_on ? {3'b000, cfg.heat_offset} : '0);

	// An empty hold register means no level seen yet: seed from this one.
	assign held_seed  = (held_level_q == '0) ? level_raw : held_level_q;
	assign drop_floor = {1'b0, level_raw} + {4'b0000, cfg.drop_margin};
	assign glitch     = {1'b0, held_seed} > drop_floor;
	assign level_f    = glitch ? held_seed : level_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_level_q <= '0;
			hold_count_q <= '0;
		end else if (adv) begin
			if (glitch) begin
				held_level_q <= held_seed;
				hold_count_q <= cfg.hold_ticks;
			end else if (hold_count_q != '0) begin
				held_level_q <= held_seed;
				hold_count_q <= hold_count_q - 12'd1;
			end else begin
				held_level_q <= level_raw;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bpt_percent.sv
// Percent target mapping, one-step tracking and report pulse.
`default_nettype none
module bpt_percent
	import bpt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic [LEVEL_W-1:0] level_f,
	input  wire logic               charging,
	input  wire logic [EMPTY_W-1:0] empty_level,
	output logic      [PCT_W-1:0]   pct_next,
	output logic                    pulse
);

	logic        [PCT_W-1:0]   percent_q;
	logic signed [LEVEL_W:0]   diff;
	logic signed [LEVEL_W+1:0] target;
	logic        [LEVEL_W-1:0] empty_ext;
	logic        [LEVEL_W-1:0] full_lvl;
	logic        [PCT_W-1:0]   pct_seed;
	logic        [PCT_W-1:0]   pct_rise;
	logic                      seed;
	logic                      rise;
	logic                      fall;

	assign empty_ext = {1'b0, empty_level};
	assign full_lvl  = empty_ext + FULL_SPAN;
	assign diff      = $signed({1'b0, level_f}) - $signed({2'b00, empty_level});
	assign target    = {diff, 1'b0};
	assign seed      = (percent_q == '0);

	always_comb begin
		if (!seed) begin
			pct_seed = percent_q;
		end else if (level_f <= empty_ext) begin
			pct_seed = '0;
		end else if (level_f > full_lvl) begin
			pct_seed = PCT_FULL;
		end else begin
			pct_seed = target[PCT_W-1:0];
		end
	end

	// Rise only while charging, fall whenever above target and above zero.
	assign rise = charging && ($signed({6'b0, pct_seed}) < target) && (pct_seed < PCT_FULL);
	assign pct_rise = rise ? pct_seed + 7'd1 : pct_seed;
	assign fall = ($signed({6'b0, pct_rise}) > target) && (pct_rise != '0);
	assign pct_next = fall ? pct_rise - 7'd1 : pct_rise;

	assign pulse = seed || (rise && is_mult20(pct_rise))
		|| (fall && (is_mult20(pct_next) || pct_next == PULSE_LOW));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			percent_q <= '0;
		end else if (adv) begin
			percent_q <= pct_next;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bpt_checker.sv
// Port-level checker for the battery percent tracker, bound to the top level.
`default_nettype none
`include "battery_percent_tracker_unit_assert.svh"
module bpt_checker
	import bpt_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [PCT_W-1:0]   percent,
	input wire logic               update_pulse,
	input wire logic [LEVEL_W-1:0] filtered_level
);

	`BPT_ASSERT_NOW(a_result_range, out_valid, (percent <= PCT_FULL) && (filtered_level <= LEVEL_MAX), "result out of range")
	`BPT_ASSERT_NOW(a_zero_reports, out_valid && (percent == '0), update_pulse, "zero percent without update pulse")
	`BPT_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(percent) && $stable(update_pulse) && $stable(filtered_level), "stalled result changed")
	`BPT_ASSERT_LATER(a_item_reaches_out, in_valid && !in_stall, out_valid, "accepted item did not reach the output")

endmodule

bind battery_percent_tracker_unit bpt_checker u_bpt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.percent        (percent),
	.update_pulse   (update_pulse),
	.filtered_level (filtered_level)
);
`default_nettype wire
